// ===== hw/rtl/spcm_pkg.sv =====
// ----------------------------------------------------------------------------
// SPIR-V cooperative matrix scanner package
// Constants shared by the scanner unit and its checker.
// ----------------------------------------------------------------------------
`default_nettype none

package spcm_pkg;

    localparam int unsigned HEADER_WORDS = 5;
    localparam int unsigned HDR_CNT_W    = 3;

    localparam int unsigned WORD_W  = 32;
    localparam int unsigned HALF_W  = 16;
    localparam int unsigned M_DATA_W = 8;

    localparam logic [HALF_W-1:0] OP_CAPABILITY   = 16'd17;
    localparam logic [HALF_W-1:0] OP_COOP_FIRST   = 16'd4456;
    localparam logic [HALF_W-1:0] OP_COOP_LAST    = 16'd4460;
    localparam logic [WORD_W-1:0] CAP_COOP_MATRIX = 32'd6022;

    localparam logic [HDR_CNT_W-1:0] HDR_LIMIT = HDR_CNT_W'(HEADER_WORDS);

endpackage

`default_nettype wire

// ===== hw/rtl/spirv_coop_matrix_scanner_unit.sv =====
// ----------------------------------------------------------------------------
// SPIR-V cooperative matrix scanner
// Scans a SPIR-V module word stream for cooperative matrix usage.
// ----------------------------------------------------------------------------
// The slave channel carries one 32-bit module word per transaction in
// s_tdata, with s_tlast set on the final word of a module. The header words
// are skipped, then instruction boundaries are followed from the word count
// in the upper half of each instruction's first word.
// On the transaction that carries s_tlast, one result transaction is issued
// on the master channel: m_tdata bit 0 is set if a cooperative matrix opcode
// or capability was seen. All scan state then clears for the next module.
// Each word is handled by compares and a counter update between the slave
// port and the result register, so one word is taken per cycle while
// s_tready is high, and the result register loads on the last word.
// The result register frees itself in the cycle it is taken, so a stalled
// master side only holds s_tready low while a result is waiting and
// m_tready is low. After reset the scan state is clear, no result is
// pending and s_tready is high.
// ----------------------------------------------------------------------------
`default_nettype none

module spirv_coop_matrix_scanner_unit (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    // s_tdata: word [31:0]
    input  wire logic [spcm_pkg::WORD_W-1:0]    s_tdata,
    input  wire logic                           s_tlast,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    // m_tdata: found [0], zero padding [7:1]
    output logic [spcm_pkg::M_DATA_W-1:0]       m_tdata,
    output logic                                m_tvalid,
    input  wire logic                           m_tready
);

    logic [spcm_pkg::HDR_CNT_W-1:0] hdr_cnt_reg, hdr_cnt_next;
    logic [spcm_pkg::HALF_W-1:0]    wtn_reg, wtn_next;
    logic                           cap_pend_reg, cap_pend_next;
    logic                           hit_reg, hit_next;
    logic                           halted_reg, halted_next;
    logic                           found_reg, found_next;
    logic                           m_valid_reg, m_valid_next;

    logic                           s_accept;
    logic [spcm_pkg::HALF_W-1:0]    opcode;
    logic [spcm_pkg::HALF_W-1:0]    wcount;

    assign s_tready = !m_valid_reg || m_tready;
    assign s_accept = s_tvalid && s_tready;
    assign opcode   = s_tdata[spcm_pkg::HALF_W-1:0];
    assign wcount   = s_tdata[spcm_pkg::WORD_W-1:spcm_pkg::HALF_W];

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(spcm_pkg::M_DATA_W-1){1'b0}}, found_reg};

    always_comb begin
        hdr_cnt_next  = hdr_cnt_reg;
        wtn_next      = wtn_reg;
        cap_pend_next = cap_pend_reg;
        hit_next      = hit_reg;
        halted_next   = halted_reg;
        found_next    = found_reg;
        m_valid_next  = m_valid_reg && !m_tready;

        if (s_accept) begin
            if (halted_reg || hit_reg) begin
                // Scanning has finished for this module; words are dropped.
            end else if (hdr_cnt_reg < spcm_pkg::HDR_LIMIT) begin
                hdr_cnt_next = hdr_cnt_reg + 1'b1;
            end else if (cap_pend_reg && s_tdata == spcm_pkg::CAP_COOP_MATRIX) begin
                cap_pend_next = 1'b0;
                hit_next      = 1'b1;
            end else if (wtn_reg != '0) begin
                cap_pend_next = 1'b0;
                wtn_next      = wtn_reg - 1'b1;
            end else if (wcount == '0) begin
                cap_pend_next = 1'b0;
                halted_next   = 1'b1;
            end else begin
                cap_pend_next = (opcode == spcm_pkg::OP_CAPABILITY);
                hit_next      = (opcode >= spcm_pkg::OP_COOP_FIRST) &&
                                (opcode <= spcm_pkg::OP_COOP_LAST);
                wtn_next      = wcount - 1'b1;
            end

            if (s_tlast) begin
                found_next    = hit_next;
                m_valid_next  = 1'b1;
                hdr_cnt_next  = '0;
                wtn_next      = '0;
                cap_pend_next = 1'b0;
                hit_next      = 1'b0;
                halted_next   = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hdr_cnt_reg  <= '0;
            wtn_reg      <= '0;
            cap_pend_reg <= 1'b0;
            hit_reg      <= 1'b0;
            halted_reg   <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            hdr_cnt_reg  <= hdr_cnt_next;
            wtn_reg      <= wtn_next;
            cap_pend_reg <= cap_pend_next;
            hit_reg      <= hit_next;
            halted_reg   <= halted_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        found_reg <= found_next;
    end

endmodule

`default_nettype wire

// ===== hw/rtl/spcm_checker.sv =====
// ----------------------------------------------------------------------------
// SPIR-V cooperative matrix scanner checker
// Port-level assertions on the scanner unit, attached by bind.
// ----------------------------------------------------------------------------
`default_nettype none

module spcm_checker (
    input wire logic                        aclk,
    input wire logic                        aresetn,
    input wire logic                        s_tlast,
    input wire logic                        s_tvalid,
    input wire logic                        s_tready,
    input wire logic [spcm_pkg::M_DATA_W-1:0] m_tdata,
    input wire logic                        m_tvalid,
    input wire logic                        m_tready
);

    // A stalled result holds its value.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    // A fresh result follows only a transaction that closed a module.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !($past(m_tvalid) && !$past(m_tready))
        |-> $past(s_tvalid && s_tready && s_tlast))
        else $error("result without a closing transaction");

    // A closing transaction always yields a result in the next cycle.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tlast |=> m_tvalid)
        else $error("closing transaction gave no result");

    // The slave side only stalls while a result is waiting to be taken.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !(m_tvalid && !m_tready) |-> s_tready)
        else $error("slave stalled without a pending result");

    // Padding bits of the result stay zero.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[spcm_pkg::M_DATA_W-1:1] == '0)
        else $error("result padding not zero");

endmodule

bind spirv_coop_matrix_scanner_unit spcm_checker u_spcm_checker (.*);

`default_nettype wire
